@@ src/u2i_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2i_pkg
// Shared constants, register indexes and the result word for the packed
// 4:2:2 to planar 4:2:0 converter.
// ----------------------------------------------------------------------------
package u2i_pkg;

  localparam int MAX_LINE_PAIRS = 2048;
  localparam int MAX_LINES      = 4096;

  localparam int PAIR_W  = 11;
  localparam int ROW_W   = 12;
  localparam int CFG_W   = 13;
  localparam int INDEX_W = 3;

  localparam logic [INDEX_W-1:0] REG_SOURCE_LINE_PAIRS  = 3'd0;
  localparam logic [INDEX_W-1:0] REG_CROP_FIRST_ROW     = 3'd1;
  localparam logic [INDEX_W-1:0] REG_CROP_FIRST_PAIR    = 3'd2;
  localparam logic [INDEX_W-1:0] REG_OUTPUT_WIDTH_PAIRS = 3'd3;
  localparam logic [INDEX_W-1:0] REG_OUTPUT_HEIGHT      = 3'd4;
  localparam logic [INDEX_W-1:0] REG_DECIMATE_BY_TWO    = 3'd5;

  typedef struct packed {
    logic [7:0]        luma_left;
    logic [7:0]        luma_right;
    logic              chroma_valid;
    logic [7:0]        cb_out;
    logic [7:0]        cr_out;
    logic [ROW_W-1:0]  out_row;
    logic [PAIR_W-1:0] out_pair;
    logic              frame_last;
  } result_t;

endpackage

@@ src/uyvy_to_i420_decimating_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uyvy_to_i420_decimating_converter
// Crops and optionally decimates a packed 4:2:2 pixel word stream and emits
// luma pairs with 4:2:0 chroma marks and output positions.
// ----------------------------------------------------------------------------
// Channel   Signals                              Direction
// input     in_valid, in_stall, frame_start,     in, stall out
//           cb_in, luma_first_in, cr_in, luma_second_in
// output    out_valid, out_stall, luma_left ...  out, stall in
// config    cfg_write, cfg_index, cfg_data       in, no handshake
//
// One word is taken per clock while in_stall is low; its result is registered
// in the output register, or in a skid register that holds a second result
// while the output is stalled. The input stalls only while the skid is full.
// Reset is synchronous and clears the position counters, the valid flags and
// the configuration registers to their defaults.
// ----------------------------------------------------------------------------
module uyvy_to_i420_decimating_converter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [u2i_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [u2i_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         frame_start,
  input  logic [7:0]                   cb_in,
  input  logic [7:0]                   luma_first_in,
  input  logic [7:0]                   cr_in,
  input  logic [7:0]                   luma_second_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   luma_left,
  output logic [7:0]                   luma_right,
  output logic                         chroma_valid,
  output logic [7:0]                   cb_out,
  output logic [7:0]                   cr_out,
  output logic [u2i_pkg::ROW_W-1:0]    out_row,
  output logic [u2i_pkg::PAIR_W-1:0]   out_pair,
  output logic                         frame_last
);
  import u2i_pkg::*;

  localparam logic [11:0] LINE_PAIRS_MAX = 12'(MAX_LINE_PAIRS);
  localparam logic [12:0] LINES_MAX      = 13'(MAX_LINES);

  logic [11:0]       source_line_pairs;
  logic [11:0]       crop_first_row;
  logic [10:0]       crop_first_pair;
  logic [11:0]       output_width_pairs;
  logic [12:0]       output_height;
  logic              decimate_by_two;

  logic [PAIR_W-1:0] source_pair_count;
  logic [12:0]       source_row_count;
  logic              frame_done;

  logic [PAIR_W-1:0] source_pair_count_next;
  logic [12:0]       source_row_count_next;
  logic              frame_done_next;

  logic              result_valid;
  result_t           result;
  result_t           out_data;
  result_t           skid_data;
  logic              skid_valid;

  logic              in_transfer;
  logic              out_transfer;

  logic [PAIR_W-1:0] sp;
  logic [12:0]       sr;
  logic              fd;
  logic [11:0]       line_len;
  logic [11:0]       wp;
  logic [12:0]       ht;
  logic              in_window;
  logic [ROW_W-1:0]  dr;
  logic [PAIR_W-1:0] dp;
  logic [ROW_W-1:0]  orow;
  logic [PAIR_W-1:0] op;
  logic              last;
  logic [11:0]       sp_inc;

  assign in_stall     = skid_valid;
  assign in_transfer  = in_valid && !skid_valid;
  assign out_transfer = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_line_pairs  <= 12'd320;
      crop_first_row     <= '0;
      crop_first_pair    <= '0;
      output_width_pairs <= 12'd88;
      output_height      <= 13'd144;
      decimate_by_two    <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SOURCE_LINE_PAIRS:  source_line_pairs  <= cfg_data[11:0];
        REG_CROP_FIRST_ROW:     crop_first_row     <= cfg_data[11:0];
        REG_CROP_FIRST_PAIR:    crop_first_pair    <= cfg_data[10:0];
        REG_OUTPUT_WIDTH_PAIRS: output_width_pairs <= cfg_data[11:0];
        REG_OUTPUT_HEIGHT:      output_height      <= cfg_data[12:0];
        REG_DECIMATE_BY_TWO:    decimate_by_two    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sp = frame_start ? '0 : source_pair_count;
    sr = frame_start ? '0 : source_row_count;
    fd = frame_start ? 1'b0 : frame_done;

    if (source_line_pairs == 12'd0) begin
      line_len = 12'd1;
    end else if (source_line_pairs > LINE_PAIRS_MAX) begin
      line_len = LINE_PAIRS_MAX;
    end else begin
      line_len = source_line_pairs;
    end
    wp = (output_width_pairs > LINE_PAIRS_MAX) ? LINE_PAIRS_MAX : output_width_pairs;
    ht = (output_height > LINES_MAX) ? LINES_MAX : output_height;

    in_window = !fd && (sr < LINES_MAX) && (sr >= {1'b0, crop_first_row}) &&
                (sp >= crop_first_pair);
    dr = sr[ROW_W-1:0] - crop_first_row;
    dp = sp - crop_first_pair;
    orow = decimate_by_two ? {1'b0, dr[ROW_W-1:1]} : dr;
    op   = decimate_by_two ? {1'b0, dp[PAIR_W-1:1]} : dp;

    result_valid = in_window && !(decimate_by_two && (dr[0] || dp[0])) &&
                   ({1'b0, op} < wp) && ({1'b0, orow} < ht);
    last = (({1'b0, op} + 12'd1) == wp) && (({1'b0, orow} + 13'd1) == ht);

    result.luma_left    = luma_first_in;
    result.luma_right   = luma_second_in;
    result.chroma_valid = !orow[0];
    result.cb_out       = orow[0] ? 8'd0 : cb_in;
    result.cr_out       = orow[0] ? 8'd0 : cr_in;
    result.out_row      = orow;
    result.out_pair     = op;
    result.frame_last   = last;

    sp_inc = {1'b0, sp} + 12'd1;
    if (sp_inc >= line_len) begin
      source_pair_count_next = '0;
      source_row_count_next  = (sr < LINES_MAX) ? sr + 13'd1 : sr;
    end else begin
      source_pair_count_next = sp_inc[PAIR_W-1:0];
      source_row_count_next  = sr;
    end
    frame_done_next = fd || (result_valid && last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_pair_count <= '0;
      source_row_count  <= '0;
      frame_done        <= 1'b0;
    end else if (in_transfer) begin
      source_pair_count <= source_pair_count_next;
      source_row_count  <= source_row_count_next;
      frame_done        <= frame_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_transfer) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_transfer && result_valid;
        end
      end else if (in_transfer && result_valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_transfer) begin
      out_data <= skid_valid ? skid_data : result;
    end
    if (out_valid && !out_transfer && in_transfer && result_valid) begin
      skid_data <= result;
    end
  end

  assign luma_left    = out_data.luma_left;
  assign luma_right   = out_data.luma_right;
  assign chroma_valid = out_data.chroma_valid;
  assign cb_out       = out_data.cb_out;
  assign cr_out       = out_data.cr_out;
  assign out_row      = out_data.out_row;
  assign out_pair     = out_data.out_pair;
  assign frame_last   = out_data.frame_last;

endmodule

@@ bench/u2i_planar_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2i_planar_checker
// Watches the configuration port and both channels of the converter. It
// keeps its own copy of the registers and of the source position, and works
// out the luma pair, chroma mark and output position that each input transfer
// should cause. Each output transfer is compared field by field with the
// oldest expected word, and every difference is counted.
// ----------------------------------------------------------------------------
module u2i_planar_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [u2i_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [u2i_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         frame_start,
  input  logic [7:0]                   cb_in,
  input  logic [7:0]                   luma_first_in,
  input  logic [7:0]                   cr_in,
  input  logic [7:0]                   luma_second_in,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [7:0]                   luma_left,
  input  logic [7:0]                   luma_right,
  input  logic                         chroma_valid,
  input  logic [7:0]                   cb_out,
  input  logic [7:0]                   cr_out,
  input  logic [u2i_pkg::ROW_W-1:0]    out_row,
  input  logic [u2i_pkg::PAIR_W-1:0]   out_pair,
  input  logic                         frame_last,
  output int                           mismatch_count,
  output int                           words_pending
);

  import u2i_pkg::*;

  logic [11:0]       line_pairs_reg;
  logic [11:0]       crop_row_reg;
  logic [10:0]       crop_pair_reg;
  logic [11:0]       width_reg;
  logic [12:0]       height_reg;
  logic              decimate_reg;

  logic [PAIR_W-1:0] src_pair;
  logic [ROW_W:0]    src_row;
  logic              frame_done;

  result_t           planar_words [$];

  initial begin
    mismatch_count = 0;
    words_pending  = 0;
  end

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic place_word(input logic fs, input logic [7:0] cb, input logic [7:0] y0,
                            input logic [7:0] cr, input logic [7:0] y1);
    int unsigned sp;
    int unsigned sr;
    int unsigned dp;
    int unsigned dr;
    int unsigned op;
    int unsigned orow;
    int unsigned wp;
    int unsigned ht;
    int unsigned line_len;
    int unsigned sh;
    bit          keep;
    bit          last;
    result_t     word;
    if (fs) begin
      src_pair   = '0;
      src_row    = '0;
      frame_done = 1'b0;
    end
    sp = src_pair;
    sr = src_row;
    sh = decimate_reg;
    wp = (width_reg > MAX_LINE_PAIRS) ? MAX_LINE_PAIRS : width_reg;
    ht = (height_reg > MAX_LINES) ? MAX_LINES : height_reg;
    keep = !frame_done && sr < MAX_LINES && sr >= crop_row_reg && sp >= crop_pair_reg;
    dr = keep ? sr - crop_row_reg : 0;
    dp = keep ? sp - crop_pair_reg : 0;
    if (sh != 0 && ((dr & 1) != 0 || (dp & 1) != 0)) keep = 1'b0;
    orow = dr >> sh;
    op   = dp >> sh;
    if (op >= wp || orow >= ht) keep = 1'b0;

    if (line_pairs_reg == 0) line_len = 1;
    else if (line_pairs_reg > MAX_LINE_PAIRS) line_len = MAX_LINE_PAIRS;
    else line_len = line_pairs_reg;
    if (sp + 1 >= line_len) begin
      src_pair = '0;
      if (sr < MAX_LINES) src_row = src_row + 1'b1;
    end else begin
      src_pair = src_pair + 1'b1;
    end

    if (keep) begin
      last = (op + 1 == wp) && (orow + 1 == ht);
      word.luma_left    = y0;
      word.luma_right   = y1;
      word.chroma_valid = ((orow & 1) == 0);
      word.cb_out       = word.chroma_valid ? cb : 8'd0;
      word.cr_out       = word.chroma_valid ? cr : 8'd0;
      word.out_row      = orow[ROW_W-1:0];
      word.out_pair     = op[PAIR_W-1:0];
      word.frame_last   = last;
      planar_words.insert(planar_words.size(), word);
      if (last) frame_done = 1'b1;
    end
  endtask

  task automatic compare_word();
    result_t want;
    if (planar_words.size() == 0) begin
      report($sformatf("output transfer row %0d pair %0d with nothing expected",
                       out_row, out_pair));
    end else begin
      want = planar_words.pop_front();
      if (luma_left !== want.luma_left)
        report($sformatf("luma_left got %0d want %0d", luma_left, want.luma_left));
      if (luma_right !== want.luma_right)
        report($sformatf("luma_right got %0d want %0d", luma_right, want.luma_right));
      if (chroma_valid !== want.chroma_valid)
        report($sformatf("chroma_valid got %0d want %0d", chroma_valid, want.chroma_valid));
      if (cb_out !== want.cb_out)
        report($sformatf("cb_out got %0d want %0d", cb_out, want.cb_out));
      if (cr_out !== want.cr_out)
        report($sformatf("cr_out got %0d want %0d", cr_out, want.cr_out));
      if (out_row !== want.out_row)
        report($sformatf("out_row got %0d want %0d", out_row, want.out_row));
      if (out_pair !== want.out_pair)
        report($sformatf("out_pair got %0d want %0d", out_pair, want.out_pair));
      if (frame_last !== want.frame_last)
        report($sformatf("frame_last got %0d want %0d", frame_last, want.frame_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      line_pairs_reg = 12'd320;
      crop_row_reg   = 12'd0;
      crop_pair_reg  = 11'd0;
      width_reg      = 12'd88;
      height_reg     = 13'd144;
      decimate_reg   = 1'b0;
      src_pair       = '0;
      src_row        = '0;
      frame_done     = 1'b0;
      planar_words.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_SOURCE_LINE_PAIRS:  line_pairs_reg = cfg_data[11:0];
          REG_CROP_FIRST_ROW:     crop_row_reg   = cfg_data[11:0];
          REG_CROP_FIRST_PAIR:    crop_pair_reg  = cfg_data[10:0];
          REG_OUTPUT_WIDTH_PAIRS: width_reg      = cfg_data[11:0];
          REG_OUTPUT_HEIGHT:      height_reg     = cfg_data[12:0];
          REG_DECIMATE_BY_TWO:    decimate_reg   = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) compare_word();
      if (in_valid && !in_stall)
        place_word(frame_start, cb_in, luma_first_in, cr_in, luma_second_in);
    end
    words_pending <= planar_words.size();
  end

endmodule

@@ bench/uyvy_to_i420_decimating_converter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uyvy_to_i420_decimating_converter_test
// Drives packed pixel words into the converter under a series of crop,
// output size and decimation settings, first a few directed frames for the
// corner cases and then random frames, mostly complete with some truncated
// or restarted. The sender transfers in bursts and the receiver stalls on
// its own pattern; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module uyvy_to_i420_decimating_converter_test;

  import u2i_pkg::*;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  localparam int RANDOM_WORDS  = 1200;
  localparam int WATCHDOG_IDLE = 2000;
  localparam int FRAME_CAP     = 300;

  logic                 clk            = 1'b0;
  logic                 rst            = 1'b1;
  logic                 cfg_write      = 1'b0;
  logic [INDEX_W-1:0]   cfg_index      = '0;
  logic [CFG_W-1:0]     cfg_data       = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic                 frame_start    = 1'b0;
  logic [7:0]           cb_in          = '0;
  logic [7:0]           luma_first_in  = '0;
  logic [7:0]           cr_in          = '0;
  logic [7:0]           luma_second_in = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic [7:0]           luma_left;
  logic [7:0]           luma_right;
  logic                 chroma_valid;
  logic [7:0]           cb_out;
  logic [7:0]           cr_out;
  logic [ROW_W-1:0]     out_row;
  logic [PAIR_W-1:0]    out_pair;
  logic                 frame_last;

  int                   mismatch_count;
  int                   words_pending;
  int                   words_sent  = 0;
  int                   burst_left  = 0;
  int                   idle_cycles = 0;
  stall_mode_t          stall_mode  = STALL_NONE;
  int                   stall_left  = 0;

  int unsigned          cur_line;
  int unsigned          cur_row;
  int unsigned          cur_height;
  int unsigned          cur_decimate;

  uyvy_to_i420_decimating_converter DUT (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .frame_start, .cb_in, .luma_first_in, .cr_in, .luma_second_in,
    .out_valid, .out_stall, .luma_left, .luma_right, .chroma_valid, .cb_out, .cr_out,
    .out_row, .out_pair, .frame_last
  );

  u2i_planar_checker planar_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .frame_start, .cb_in, .luma_first_in, .cr_in, .luma_second_in,
    .out_valid, .out_stall, .luma_left, .luma_right, .chroma_valid, .cb_out, .cr_out,
    .out_row, .out_pair, .frame_last,
    .mismatch_count, .words_pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_IDLE) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_word(input logic fs, input logic [7:0] cb, input logic [7:0] y0,
                           input logic [7:0] cr, input logic [7:0] y1);
    int gap;
    if (burst_left == 0) burst_left = $urandom_range(1, 40);
    in_valid       <= 1'b1;
    frame_start    <= fs;
    cb_in          <= cb;
    luma_first_in  <= y0;
    cr_in          <= cr;
    luma_second_in <= y1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
    burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_frame(input int words, input bit noisy);
    bit fs;
    for (int k = 0; k < words; k++) begin
      fs = (k == 0);
      if (noisy && $urandom_range(0, 15) == 0) fs = ~fs;
      send_word(fs, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned line, input int unsigned row,
                               input int unsigned pair, input int unsigned width,
                               input int unsigned height, input int unsigned dec);
    logic [INDEX_W-1:0] idx [6];
    int unsigned        vals [6];
    int                 bits [6];
    int unsigned        mask;
    idx  = '{REG_SOURCE_LINE_PAIRS, REG_CROP_FIRST_ROW, REG_CROP_FIRST_PAIR,
             REG_OUTPUT_WIDTH_PAIRS, REG_OUTPUT_HEIGHT, REG_DECIMATE_BY_TWO};
    vals = '{line, row, pair, width, height, dec};
    bits = '{12, 12, 11, 12, 13, 1};
    cur_line     = (line == 0) ? 1 : ((line > MAX_LINE_PAIRS) ? MAX_LINE_PAIRS : line);
    cur_row      = row;
    cur_height   = (height > MAX_LINES) ? MAX_LINES : height;
    cur_decimate = dec;
    for (int i = 0; i < 6; i++) begin
      mask = (1 << bits[i]) - 1;
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= CFG_W'((vals[i] & mask) | ($urandom & ~mask));
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    int base;
    int full;
    int words;
    int frames;
    bit noisy;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, byte extremes and a restart in the middle of a frame.
    send_word(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(3, 1'b0);
    send_word(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h00);

    // Small window with odd rows and a frame end followed by ignored words.
    settle();
    apply_setting(4, 1, 1, 2, 2, 0);
    send_frame(20, 1'b0);

    // Zero line length and zero width, then zero height.
    settle();
    apply_setting(0, 0, 0, 0, 3, 0);
    send_frame(6, 1'b0);
    settle();
    apply_setting(3, 0, 0, 2, 0, 1);
    send_frame(6, 1'b0);

    // Decimation on both axes.
    settle();
    apply_setting(8, 0, 0, 4, 3, 1);
    send_frame(48, 1'b0);

    // Line and width above their limits.
    settle();
    apply_setting(4095, 0, 0, 4095, 1, 0);
    send_frame(40, 1'b0);

    // Window that starts below the source lines sent.
    settle();
    apply_setting(0, 4095, 0, 1, 8191, 0);
    send_frame(40, 1'b0);

    base = words_sent;
    while (words_sent - base < RANDOM_WORDS) begin
      settle();
      apply_setting(
        ($urandom_range(0, 11) == 0) ? 0 : (($urandom_range(0, 11) == 0) ? 4095 :
                                             $urandom_range(1, 10)),
        $urandom_range(0, 3),
        ($urandom_range(0, 15) == 0) ? 2047 : $urandom_range(0, 4),
        ($urandom_range(0, 11) == 0) ? 4095 : $urandom_range(0, 8),
        ($urandom_range(0, 11) == 0) ? 8191 : $urandom_range(0, 5),
        $urandom_range(0, 1));
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        full = cur_line * (cur_row + (cur_height << cur_decimate) + 1);
        if (full > FRAME_CAP) full = FRAME_CAP;
        noisy = ($urandom_range(0, 4) == 0);
        words = noisy ? $urandom_range(1, full) : full;
        send_frame(words, noisy);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && words_pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
